[hw/rtl/vsa_pkg.sv]
// Shared types and constants for the voice slot allocator.
// No dependencies.
package vsa_pkg;

  localparam int ACTION_W   = 2;
  localparam int ID_W       = 6;
  localparam int VER_W      = 32;
  localparam int SLOT_OUT_W = 4;
  localparam int CFG_W      = 5;
  // wide enough for slots_in_use and any slot count up to 64
  localparam int CNT_W      = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PLAY  = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_STOP  = 2'd2,
    ACT_END   = 2'd3
  } action_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic cfg_load;
  } vsa_cmd_t;

  typedef struct packed {
    logic out_free;
  } vsa_sts_t;

endpackage

[hw/rtl/voice_slot_allocator.sv]
// Voice slot allocator top level: sequencer plus datapath.
// A request is registered, then executed in S_EXEC once the result register is free of a stalled result.
// Requests are taken only in S_IDLE, so each one's generation RAM read and write end before the next is taken.
// A new request is taken while the previous result waits on out_stall.
// Reset (sync, rst_n low): slots_in_use = 16, pointer 0, all slots inactive,
// generations read as zero through per-slot valid bits; no clearing pass.
module voice_slot_allocator
  import vsa_pkg::*;
#(
  parameter int SLOT_COUNT = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ACTION_W-1:0]   in_action,
  input  logic [ID_W-1:0]       in_slot_id,
  input  logic [VER_W-1:0]      in_handle_version,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_ok,
  output logic [SLOT_OUT_W-1:0] out_granted_slot,
  output logic [VER_W-1:0]      out_granted_version,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_slots_in_use
);

  vsa_cmd_t cmd;
  vsa_sts_t sts;

  vsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  vsa_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_action           (in_action),
    .in_slot_id          (in_slot_id),
    .in_handle_version   (in_handle_version),
    .cfg_slots_in_use    (cfg_slots_in_use),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_ok              (out_ok),
    .out_granted_slot    (out_granted_slot),
    .out_granted_version (out_granted_version)
  );

endmodule

[hw/rtl/vsa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vsa_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [DATA_W-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [DATA_W-1:0]                     rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/vsa_ctrl.sv]
// Sequencer for the voice slot allocator: load and execute phases.
// Depends on vsa_pkg.
module vsa_ctrl
  import vsa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  vsa_sts_t sts,
  output vsa_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd.load     = 1'b0;
    cmd.exec     = 1'b0;
    cmd.cfg_load = 1'b0;
    in_stall     = 1'b1;
    cfg_ready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall     = 1'b0;
        cfg_ready    = 1'b1;
        cmd.cfg_load = cfg_valid;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hw/rtl/vsa_dp.sv]
// Datapath: slot state, round-robin search, generation RAM, result register.
// Depends on vsa_pkg and vsa_ram.
module vsa_dp
  import vsa_pkg::*;
#(
  parameter int SLOT_COUNT = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  vsa_cmd_t              cmd,
  output vsa_sts_t              sts,
  input  logic [ACTION_W-1:0]   in_action,
  input  logic [ID_W-1:0]       in_slot_id,
  input  logic [VER_W-1:0]      in_handle_version,
  input  logic [CFG_W-1:0]      cfg_slots_in_use,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_ok,
  output logic [SLOT_OUT_W-1:0] out_granted_slot,
  output logic [VER_W-1:0]      out_granted_version
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [CFG_W-1:0]      slots_r;
  logic [SLOT_COUNT-1:0] active_r, active_nxt;
  logic [SLOT_COUNT-1:0] gen_vld_r, gen_vld_nxt;
  logic [IW-1:0]         next_r, next_nxt;
  action_t               act_r;
  logic [ID_W-1:0]       id_r;
  logic [VER_W-1:0]      ver_r;
  logic [IW-1:0]         addr_r;
  logic                  rd_vld_r;
  logic                  out_valid_r;
  logic                  ok_r, ok_nxt;
  logic [SLOT_OUT_W-1:0] slot_r, slot_nxt;
  logic [VER_W-1:0]      gver_r, gver_nxt;

  logic [CNT_W-1:0]      n;
  logic [IW-1:0]         start, pick, hi_pick, lo_pick, load_addr, rd_addr;
  logic [SLOT_COUNT-1:0] free, hi;
  logic [VER_W-1:0]      rdata, gen_cur, gen_new;
  logic                  ram_we, hok, id_in;
  logic [CNT_W-1:0]      p1;

  assign n = (CNT_W'(slots_r) > CNT_W'(SLOT_COUNT)) ? CNT_W'(SLOT_COUNT)
                                                     : CNT_W'(slots_r);

  // rotating priority search from the pointer
  always_comb begin
    start   = (CNT_W'(next_r) < n) ? next_r : '0;
    hi_pick = '0;
    lo_pick = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      free[i] = !active_r[i] && (CNT_W'(i) < n);
      hi[i]   = free[i] && (CNT_W'(i) >= CNT_W'(start));
      if (free[i]) lo_pick = IW'(i);
      if (hi[i])   hi_pick = IW'(i);
    end
    pick = (|hi) ? hi_pick : ((|free) ? lo_pick : start);
  end

  assign load_addr = (action_t'(in_action) == ACT_PLAY) ? pick : IW'(in_slot_id);
  assign rd_addr   = cmd.load ? load_addr : addr_r;

  assign gen_cur = rd_vld_r ? rdata : '0;
  assign gen_new = gen_cur + 1'b1;
  assign id_in   = CNT_W'(id_r) < n;
  assign hok     = (ver_r != '0) && id_in && active_r[addr_r] && (gen_cur == ver_r);
  assign p1      = CNT_W'(addr_r) + 1'b1;

  always_comb begin
    active_nxt  = active_r;
    gen_vld_nxt = gen_vld_r;
    next_nxt    = next_r;
    ram_we      = 1'b0;
    ok_nxt      = 1'b0;
    slot_nxt    = id_r[SLOT_OUT_W-1:0];
    gver_nxt    = '0;
    if (cmd.exec) begin
      case (act_r)
        ACT_PLAY: begin
          slot_nxt = '0;
          if (n != '0) begin
            ram_we              = 1'b1;
            gen_vld_nxt[addr_r] = 1'b1;
            active_nxt[addr_r]  = 1'b1;
            next_nxt            = (p1 == n) ? '0 : IW'(p1);
            ok_nxt              = 1'b1;
            slot_nxt            = SLOT_OUT_W'(addr_r);
            gver_nxt            = gen_new;
          end
        end
        ACT_QUERY: ok_nxt = hok;
        ACT_STOP: begin
          ok_nxt = hok;
          if (hok) active_nxt[addr_r] = 1'b0;
        end
        ACT_END: begin
          if (id_in) active_nxt[addr_r] = 1'b0;
        end
        default: ok_nxt = 1'b0;
      endcase
    end
  end

  vsa_ram #(
    .DATA_W (VER_W),
    .DEPTH  (SLOT_COUNT)
  ) u_gen_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (gen_new),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r     <= CFG_RESET;
      active_r    <= '0;
      gen_vld_r   <= '0;
      next_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cfg_load) slots_r <= cfg_slots_in_use;
      active_r  <= active_nxt;
      gen_vld_r <= gen_vld_nxt;
      next_r    <= next_nxt;
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_vld_r <= gen_vld_r[rd_addr];
    if (cmd.load) begin
      act_r  <= action_t'(in_action);
      id_r   <= in_slot_id;
      ver_r  <= in_handle_version;
      addr_r <= load_addr;
    end
    if (cmd.exec) begin
      ok_r   <= ok_nxt;
      slot_r <= slot_nxt;
      gver_r <= gver_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_ok              = ok_r;
  assign out_granted_slot    = slot_r;
  assign out_granted_version = gver_r;

  a_play_marks_active: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && act_r == ACT_PLAY && n != '0) |=> active_r[addr_r])
    else $error("played slot not marked active");

  a_pointer_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && act_r == ACT_PLAY && n != '0) |=> (CNT_W'(next_r) < n))
    else $error("next slot pointer out of range after play");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.exec))
    else $error("result shown without an executed request");

endmodule

[test/voice_slot_allocator_test.sv]
// Self-checking testbench for voice_slot_allocator: directed rows, then paced random requests.
// Results are checked against an in-bench model of the slot pool and its handle check, or typed directed-row grants.
// Depends on vsa_pkg and the voice_slot_allocator RTL.
module voice_slot_allocator_test
  import vsa_pkg::*;
();

  localparam int SLOTS = 16;
  localparam int NO_CFG = -1;
  localparam int RANDOM_CFG = -2;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic             ok;
    logic [3:0]       slot;
    logic [VER_W-1:0] version;
  } grant_t;

  typedef struct {
    int               cfg;
    action_t          act;
    logic [ID_W-1:0]  id;
    logic [VER_W-1:0] ver;
    bit               typed;
    grant_t           grant;
  } stim_row_t;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} pacing_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [ACTION_W-1:0]   in_action;
  logic [ID_W-1:0]       in_slot_id;
  logic [VER_W-1:0]      in_handle_version;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_ok;
  logic [SLOT_OUT_W-1:0] out_granted_slot;
  logic [VER_W-1:0]      out_granted_version;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_slots_in_use;

  voice_slot_allocator #(.SLOT_COUNT(SLOTS)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_slot_id          (in_slot_id),
    .in_handle_version   (in_handle_version),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_ok              (out_ok),
    .out_granted_slot    (out_granted_slot),
    .out_granted_version (out_granted_version),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_slots_in_use    (cfg_slots_in_use)
  );

  // pool model
  bit               slot_live [SLOTS];
  logic [VER_W-1:0] slot_gen [SLOTS];
  int               play_ptr;
  int               slots_cfg;

  grant_t expected_grants [$];
  int     mismatches;
  int     quiet_cycles;
  int     idle_pct;
  int     stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic grant_t predict_request(action_t act, logic [ID_W-1:0] id,
                                             logic [VER_W-1:0] ver);
    grant_t g;
    int     live;
    int     start;
    int     pick;
    bit     handle_good;
    live = (slots_cfg > SLOTS) ? SLOTS : slots_cfg;
    handle_good = (ver != '0) && (id < live) && slot_live[id[3:0]] &&
                  (slot_gen[id[3:0]] == ver);
    g.ok = 1'b0;
    g.slot = id[3:0];
    g.version = '0;
    case (act)
      ACT_PLAY: begin
        g.slot = '0;
        if (live != 0) begin
          start = (play_ptr < live) ? play_ptr : 0;
          pick = start;
          for (int k = 0; k < live; k++) begin
            if (!slot_live[(start + k) % live]) begin
              pick = (start + k) % live;
              break;
            end
          end
          play_ptr = (pick + 1) % live;
          slot_gen[pick] = slot_gen[pick] + 1'b1;
          slot_live[pick] = 1'b1;
          g.ok = 1'b1;
          g.slot = 4'(pick);
          g.version = slot_gen[pick];
        end
      end
      ACT_QUERY: g.ok = handle_good;
      ACT_STOP: begin
        if (handle_good) begin
          slot_live[id[3:0]] = 1'b0;
          g.ok = 1'b1;
        end
      end
      default: begin
        if (id < live) slot_live[id[3:0]] = 1'b0;
      end
    endcase
    return g;
  endfunction

  task automatic issue_request(action_t act, logic [ID_W-1:0] id, logic [VER_W-1:0] ver,
                               bit typed, grant_t typed_grant);
    grant_t predicted;
    predicted = predict_request(act, id, ver);
    expected_grants.insert(expected_grants.size(), typed ? typed_grant : predicted);
    in_valid <= 1'b1;
    in_action <= act;
    in_slot_id <= id;
    in_handle_version <= ver;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task automatic sender_gap();
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
  endtask

  task automatic write_slots_in_use(logic [CFG_W-1:0] value);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_slots_in_use <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    slots_cfg = value;
  endtask

  task automatic set_pacing(pacing_t mode);
    idle_pct = (mode == IDLE_SENDER) ? 67 : (mode == IDLE_BOTH) ? 33 : 0;
    stall_pct = (mode == IDLE_RECEIVER) ? 67 : (mode == IDLE_BOTH) ? 33 : 0;
  endtask

  task automatic random_request();
    action_t          act;
    logic [ID_W-1:0]  id;
    logic [VER_W-1:0] ver;
    int               pick;
    int               kind;
    pick = $urandom_range(0, 99);
    id = 6'($urandom_range(0, 63));
    ver = $urandom;
    if (pick < 35) begin
      act = ACT_PLAY;
    end else if (pick < 85) begin
      act = (pick < 60) ? ACT_QUERY : ACT_STOP;
      kind = $urandom_range(0, 9);
      if (kind <= 7) id = 6'($urandom_range(0, SLOTS - 1));
      if (kind <= 5) ver = slot_gen[id[3:0]];
      else if (kind == 6) ver = slot_gen[id[3:0]] - 1'b1;
      else if (kind == 7) ver = '0;
    end else begin
      act = ACT_END;
      if ($urandom_range(0, 3) != 0) id = 6'($urandom_range(0, SLOTS - 1));
    end
    issue_request(act, id, ver, 1'b0, '0);
  endtask

  // result checker
  always @(posedge clk) begin : check_grants
    grant_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_grants.size() == 0) begin
        $display("%0t: unexpected result ok=%0d slot=%0d version=%h", $time, out_ok,
                 out_granted_slot, out_granted_version);
        mismatches++;
      end else begin
        want = expected_grants.pop_front();
        if (out_ok !== want.ok) begin
          $display("%0t: ok expected %0d actual %0d", $time, want.ok, out_ok);
          mismatches++;
        end
        if (out_granted_slot !== want.slot) begin
          $display("%0t: granted_slot expected %0d actual %0d", $time, want.slot,
                   out_granted_slot);
          mismatches++;
        end
        if (out_granted_version !== want.version) begin
          $display("%0t: granted_version expected %h actual %h", $time, want.version,
                   out_granted_version);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("voice_slot_allocator_test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    stim_row_t directed_rows [25];
    int        phase_cfg [7];
    pacing_t   phase_pacing [7];
    int        phase_items [7];
    int        cfg;
    directed_rows = '{
      '{NO_CFG,     ACT_QUERY, 6'd0,  32'd0,          1'b1, '{1'b0, 4'd0,  32'd0}},
      '{NO_CFG,     ACT_PLAY,  6'd63, 32'hFFFF_FFFF,  1'b1, '{1'b1, 4'd0,  32'd1}},
      '{NO_CFG,     ACT_PLAY,  6'd0,  32'd0,          1'b1, '{1'b1, 4'd1,  32'd1}},
      '{NO_CFG,     ACT_QUERY, 6'd0,  32'd1,          1'b1, '{1'b1, 4'd0,  32'd0}},
      '{NO_CFG,     ACT_QUERY, 6'd1,  32'hFFFF_FFFF,  1'b1, '{1'b0, 4'd1,  32'd0}},
      '{NO_CFG,     ACT_QUERY, 6'd63, 32'd1,          1'b1, '{1'b0, 4'd15, 32'd0}},
      '{NO_CFG,     ACT_STOP,  6'd0,  32'd2,          1'b1, '{1'b0, 4'd0,  32'd0}},
      '{NO_CFG,     ACT_STOP,  6'd0,  32'd1,          1'b1, '{1'b1, 4'd0,  32'd0}},
      '{NO_CFG,     ACT_STOP,  6'd0,  32'd1,          1'b1, '{1'b0, 4'd0,  32'd0}},
      '{NO_CFG,     ACT_END,   6'd1,  32'd0,          1'b1, '{1'b0, 4'd1,  32'd0}},
      '{NO_CFG,     ACT_END,   6'd48, 32'd0,          1'b1, '{1'b0, 4'd0,  32'd0}},
      '{NO_CFG,     ACT_PLAY,  6'd0,  32'd0,          1'b0, '0},
      '{2,          ACT_PLAY,  6'd0,  32'd0,          1'b0, '0},
      '{NO_CFG,     ACT_PLAY,  6'd0,  32'd0,          1'b0, '0},
      '{NO_CFG,     ACT_PLAY,  6'd0,  32'd0,          1'b0, '0},
      '{NO_CFG,     ACT_QUERY, 6'd2,  32'd1,          1'b0, '0},
      '{0,          ACT_PLAY,  6'd5,  32'd7,          1'b1, '{1'b0, 4'd0,  32'd0}},
      '{NO_CFG,     ACT_END,   6'd0,  32'd0,          1'b0, '0},
      '{31,         ACT_PLAY,  6'd0,  32'd0,          1'b0, '0},
      '{NO_CFG,     ACT_QUERY, 6'd21, 32'hAAAA_AAAA,  1'b0, '0},
      '{NO_CFG,     ACT_STOP,  6'd42, 32'h5555_5555,  1'b0, '0},
      '{1,          ACT_PLAY,  6'd0,  32'd0,          1'b0, '0},
      '{NO_CFG,     ACT_PLAY,  6'd0,  32'd0,          1'b0, '0},
      '{16,         ACT_QUERY, 6'd0,  32'd2,          1'b0, '0},
      '{NO_CFG,     ACT_END,   6'd15, 32'hFFFF_FFFF,  1'b0, '0}
    };
    phase_cfg = '{16, 5, 16, RANDOM_CFG, 1, RANDOM_CFG, 16};
    phase_pacing = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE,
                     IDLE_RECEIVER, IDLE_BOTH};
    phase_items = '{80, 70, 80, 70, 40, 60, 60};

    foreach (slot_live[i]) begin
      slot_live[i] = 1'b0;
      slot_gen[i] = '0;
    end
    play_ptr = 0;
    slots_cfg = CFG_RESET;
    mismatches = 0;
    quiet_cycles = 0;
    set_pacing(IDLE_NONE);
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_action <= ACT_PLAY;
    in_slot_id <= '0;
    in_handle_version <= '0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_slots_in_use <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].cfg != NO_CFG) write_slots_in_use(CFG_W'(directed_rows[r].cfg));
      issue_request(directed_rows[r].act, directed_rows[r].id, directed_rows[r].ver,
                    directed_rows[r].typed, directed_rows[r].grant);
    end

    for (int p = 0; p < 7; p++) begin
      cfg = (phase_cfg[p] == RANDOM_CFG) ? $urandom_range(0, 31) : phase_cfg[p];
      write_slots_in_use(CFG_W'(cfg));
      set_pacing(phase_pacing[p]);
      for (int n = 0; n < phase_items[p]; n++) begin
        // hold off the sender until the pipeline is empty
        if (p == 2 && n == 40) drain_results();
        sender_gap();
        random_request();
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("voice_slot_allocator_test passed");
    end else begin
      $display("voice_slot_allocator_test failed");
    end
    $finish;
  end

endmodule
